>>> design/sha512_hash_top_macros.svh
// Assertion macros for the SHA-512 hasher checker.
// Included by the checker file only; no other dependencies.
`ifndef SHA512_HASH_TOP_MACROS_SVH
`define SHA512_HASH_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sha512_pkg.sv
// Package for the SHA-512 hasher: constants, types, round functions.
// Used by the sequencer, round unit and top level; no dependencies.
`default_nettype none
package sha512_pkg;

    localparam int WordW = 64;
    localparam int Rounds = 80;

    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // control from sequencer to the round unit
    typedef struct packed {
        logic init;    // copy hash words into working vars
        logic round;   // run one round
        logic fold;    // add working vars into hash words
        logic reset_h; // reload initial hash values
    } core_ctrl_t;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] RK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage
`default_nettype wire

>>> design/sha512_core.sv
// SHA-512 round unit: hash words, working variables and the 16-word schedule.
// One round per cycle under control of the sequencer. Depends on sha512_pkg.
`default_nettype none
module sha512_core (
    input  wire                      clk,
    input  wire                      rst_n,
    input  sha512_pkg::core_ctrl_t   ctrl,
    input  wire [6:0]                round_idx,
    input  wire [63:0]               blk [16],
    input  wire [2:0]                rd_idx,
    output logic [63:0]              hash_word
);
    import sha512_pkg::*;

    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [63:0] w_reg [16];
    logic [63:0] w_cur, w_new, t1, t2, s0, s1;

    // schedule window shifts each round; w_reg[0] is the current word
    always_comb
    begin
        s0 = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1 = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + RK[round_idx] + w_cur;
        t2 = (rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 8; k++)
                h_reg[k] <= IV[k];
        end
        else if (ctrl.reset_h)
        begin
            for (int k = 0; k < 8; k++)
                h_reg[k] <= IV[k];
        end
        else if (ctrl.fold)
        begin
            for (int k = 0; k < 8; k++)
                h_reg[k] <= h_reg[k] + v_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            for (int k = 0; k < 8; k++)
                v_reg[k] <= h_reg[k];
            for (int k = 0; k < 16; k++)
                w_reg[k] <= blk[k];
        end
        else if (ctrl.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int k = 0; k < 15; k++)
                w_reg[k] <= w_reg[k + 1];
            w_reg[15] <= w_new;
        end
    end

    assign hash_word = h_reg[rd_idx];

endmodule
`default_nettype wire

>>> design/sha512_ctrl.sv
// SHA-512 sequencer: block buffer fill, padding, length count, rounds, output.
// Drives sha512_core. Depends on sha512_pkg.
`default_nettype none
module sha512_ctrl (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire [63:0]               in_data,
    input  wire [3:0]                in_count,
    input  wire                      in_last,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [2:0]               out_index,
    output sha512_pkg::core_ctrl_t   ctrl,
    output logic [6:0]               round_idx,
    output logic [63:0]              blk [16]
);
    import sha512_pkg::*;

    state_t      state_reg, state_next;
    logic [63:0] buf_reg [16];
    logic [3:0]  fill_reg, fill_next;      // words held
    logic [127:0] len_reg, len_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        pad_reg, pad_next;        // final padded block pending
    logic        emit_reg, emit_next;      // digest after this block
    logic [63:0] len_hi_reg, len_lo_reg;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [63:0] wr_data, mask, padded;
    logic [3:0]  cnt;
    logic        pad_word_reg;   // pad byte still to be placed at word fill_reg
    logic        fin_reg;        // final block of this message being loaded
    logic        len_fits;
    logic [4:0]  used_words;     // words taken by data and pad on the last transfer
    logic        fits_one;       // data, pad and length fit in one block

    always_comb
    begin
        cnt = (!in_last || in_count > 4'd8) ? 4'd8 : in_count;
        mask = (cnt == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {cnt, 3'b000});
        padded = (in_data & mask) | ((cnt == 4'd8) ? 64'd0
                 : ({56'd0, PadByte} << {3'd7 - cnt[2:0], 3'b000}));
    end

    // a last word in slot 15 fills the block, so the pad always goes to a second one
    assign used_words = {1'b0, fill_reg + 4'd1} + {4'd0, cnt == 4'd8};
    assign fits_one = (used_words <= 5'd14) && (fill_reg != 4'd15);

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        len_next = len_reg;
        rnd_next = rnd_reg;
        idx_next = idx_reg;
        pad_next = pad_reg;
        emit_next = emit_reg;
        in_ready = 1'b0;
        out_valid = 1'b0;
        ctrl = '0;
        wr_en = 1'b0;
        wr_addr = fill_reg;
        wr_data = in_data;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    wr_en = 1'b1;
                    len_next = len_reg + {121'd0, cnt, 3'b000};
                    wr_data = in_last ? padded : in_data;
                    if (!in_last)
                    begin
                        fill_next = fill_reg + 4'd1;
                        if (fill_reg == 4'd15)
                        begin
                            state_next = ST_LOAD;
                            emit_next = 1'b0;
                            pad_next = 1'b0;
                        end
                    end
                    else
                    begin
                        // word written holds data and, if cnt<8, the pad byte
                        fill_next = fill_reg + 4'd1;
                        emit_next = 1'b0;
                        pad_next = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                ctrl.init = 1'b1;
                rnd_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                ctrl.round = 1'b1;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'(Rounds - 1))
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                ctrl.fold = 1'b1;
                fill_next = '0;
                if (emit_reg)
                begin
                    idx_next = '0;
                    state_next = ST_EMIT;
                end
                else if (pad_reg)
                begin
                    // second padded block: zeros, length and possibly the pad word
                    emit_next = 1'b1;
                    pad_next = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        ctrl.reset_h = 1'b1;
                        len_next = '0;
                        fill_next = '0;
                        emit_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Block assembly for LOAD: on the final pass, words after the fill are zero,
    // the pad byte word sits at fill-1 or fill, and the length fills words 14/15 if free.
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            blk[k] = buf_reg[k];
            if (fin_reg)
            begin
                if (4'(k) >= fill_reg)
                    blk[k] = (pad_word_reg && 4'(k) == fill_reg) ? {PadByte, 56'd0} : 64'd0;
                if (k == 14 && len_fits)
                    blk[k] = len_hi_reg;
                if (k == 15 && len_fits)
                    blk[k] = len_lo_reg;
            end
        end
    end

    // length fits if words 14,15 are free after data and pad
    assign len_fits = ({1'b0, fill_reg} + {4'd0, pad_word_reg}) <= 5'd14;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
            idx_reg <= '0;
            pad_reg <= 1'b0;
            emit_reg <= 1'b0;
            fin_reg <= 1'b0;
            pad_word_reg <= 1'b0;
            len_hi_reg <= '0;
            len_lo_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            rnd_reg <= rnd_next;
            idx_reg <= idx_next;
            if (state_reg == ST_IDLE && in_valid && in_last)
            begin
                // fill counts the word just written; pad word pending if cnt==8.
                // A full data block goes out unchanged before the padding block.
                fill_reg <= fill_next;
                fin_reg <= (fill_reg != 4'd15);
                pad_word_reg <= (cnt == 4'd8);
                len_hi_reg <= len_next[127:64];
                len_lo_reg <= len_next[63:0];
                emit_reg <= fits_one;
                pad_reg <= !fits_one;
            end
            else if (state_reg == ST_FOLD && pad_reg && !emit_reg)
            begin
                // second block: everything already placed except possibly the pad word
                fill_reg <= '0;
                fin_reg <= 1'b1;
                pad_word_reg <= pad_word_reg && fill_reg == 4'd0;
                emit_reg <= 1'b1;
                pad_reg <= 1'b0;
            end
            else
            begin
                fill_reg <= fill_next;
                emit_reg <= emit_next;
                pad_reg <= pad_next;
                if (state_reg == ST_EMIT && state_next == ST_IDLE)
                    fin_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_reg[wr_addr] <= wr_data;
    end

    assign round_idx = rnd_reg;
    assign out_index = idx_reg;

endmodule
`default_nettype wire

>>> design/sha512_hash_top.sv
// SHA-512 hasher: top level joining the sequencer and the round unit.
// Depends on sha512_pkg, sha512_ctrl, sha512_core.
//
// Usage:
//  - s_axis: tdata = message word (first byte in bits 63:56), tuser = byte
//    count (4 bits), tlast = last item of the message.
//  - m_axis: tdata = digest word, tuser = word index (3 bits), tlast on word 7.
//  - A non-final transfer is taken at once, except the sixteenth word of a
//    block, which is followed by load, the rounds of the shared round unit
//    and fold before the next transfer is taken.
//  - The final transfer runs one or two padded blocks, then offers the eight
//    digest words, one per cycle while m_axis_tready.
//  - s_axis_tready is low while rounds run or digest words wait; a stalled
//    receiver holds the current digest word.
//  - Reset loads the initial hash values and clears length and fill.
`default_nettype none
module sha512_hash_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // data_word
    input  wire  [3:0]  s_axis_tuser,   // byte_count
    input  wire         s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // is_last_word
);
    import sha512_pkg::*;

    core_ctrl_t  ctrl;
    logic [6:0]  round_idx;
    logic [63:0] blk [16];
    logic [2:0]  out_index;

    sha512_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata), .in_count(s_axis_tuser), .in_last(s_axis_tlast),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_index(out_index),
        .ctrl(ctrl), .round_idx(round_idx), .blk(blk)
    );

    sha512_core u_core (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .round_idx(round_idx),
        .blk(blk), .rd_idx(out_index), .hash_word(m_axis_tdata)
    );

    assign m_axis_tuser = out_index;
    assign m_axis_tlast = (out_index == 3'd7);

endmodule
`default_nettype wire

>>> design/sha512_checker.sv
// Port-level checker for sha512_hash_top, bound to the top level.
// Depends on sha512_hash_top_macros.svh.
`default_nettype none
`include "sha512_hash_top_macros.svh"
module sha512_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [2:0]  m_axis_tuser,
    input wire        m_axis_tlast
);
    `SHA_ASSERT_IMP(a_no_overlap, clk, rst_n, m_axis_tvalid, !s_axis_tready,
        "input taken while digest pending")
    `SHA_ASSERT_IMP(a_last_idx, clk, rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == 3'd7),
        "tlast not on word 7")
    `SHA_ASSERT_NEXT(a_idx_step, clk, rst_n,
        m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1,
        "digest word index did not advance")
endmodule

bind sha512_hash_top sha512_checker u_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

>>> tb/sha512_hash_top_tb.sv
// Self-checking testbench for the streaming SHA-512 hasher sha512_hash_top.
// Depends on sha512_pkg (IV and round constants); predicts digests in-line.
`timescale 1ns / 1ps
`default_nettype none

class digest_scoreboard;
    logic [63:0] hash_state [8];
    logic [63:0] blk [16];
    int unsigned fill;
    logic [127:0] msg_bits;
    logic [63:0] exp_word [$];
    logic [2:0] exp_idx [$];
    logic exp_lastw [$];
    int errors;

    function new();
        restart();
        errors = 0;
    endfunction

    function void restart();
        for (int k = 0; k < 8; k++)
            hash_state[k] = sha512_pkg::IV[k];
        fill = 0;
        msg_bits = '0;
    endfunction

    function logic [63:0] ror(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function void compress();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] wr, t1, t2, a, b;
        for (int k = 0; k < 16; k++)
            w[k] = blk[k];
        for (int k = 0; k < 8; k++)
            v[k] = hash_state[k];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                wr = w[r];
            else
            begin
                a = w[(r - 2) & 15];
                b = w[(r - 15) & 15];
                wr = (ror(a, 19) ^ ror(a, 61) ^ (a >> 6)) + w[(r - 7) & 15]
                   + (ror(b, 1) ^ ror(b, 8) ^ (b >> 7)) + w[r & 15];
                w[r & 15] = wr;
            end
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::RK[r] + wr;
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            hash_state[k] += v[k];
    endfunction

    function void put_byte(logic [7:0] val);
        blk[fill >> 3][(7 - (fill & 7)) * 8 +: 8] = val;
        fill = (fill + 1) & 127;
    endfunction

    // note one accepted input transfer
    function void note_input(logic [63:0] data, logic [3:0] cnt, logic last);
        int unsigned n;
        n = !last ? 8 : (cnt > 8 ? 8 : cnt);
        for (int i = 0; i < n; i++)
        begin
            put_byte(data[(7 - i) * 8 +: 8]);
            if (fill == 0)
                compress();
        end
        msg_bits += 128'(n * 8);
        if (!last)
            return;
        put_byte(sha512_pkg::PadByte);
        if (fill > 112 || fill == 0)
        begin
            // length does not fit: pad out this block first
            while (fill != 0)
                put_byte(8'h00);
            compress();
        end
        while (fill < 112)
            put_byte(8'h00);
        blk[14] = msg_bits[127:64];
        blk[15] = msg_bits[63:0];
        compress();
        for (int k = 0; k < 8; k++)
        begin
            exp_word.push_back(hash_state[k]);
            exp_idx.push_back(k[2:0]);
            exp_lastw.push_back(k == 7);
        end
        restart();
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        errors++;
    endfunction

    function void check_result(logic [63:0] data, logic [2:0] idx, logic lastw);
        if (exp_word.size() == 0)
        begin
            report("unexpected digest word", data, 64'h0);
            return;
        end
        if (data !== exp_word[0])
            report("digest word", data, exp_word[0]);
        if (idx !== exp_idx[0])
            report("word index", 64'(idx), 64'(exp_idx[0]));
        if (lastw !== exp_lastw[0])
            report("last word flag", 64'(lastw), 64'(exp_lastw[0]));
        void'(exp_word.pop_front());
        void'(exp_idx.pop_front());
        void'(exp_lastw.pop_front());
    endfunction
endclass

module sha512_hash_top_tb;
    localparam int IdleLimit = 20000;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata;   // data_word
    logic [3:0] s_axis_tuser;    // byte_count
    logic s_axis_tlast;          // is_last
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [63:0] m_axis_tdata;   // digest_word
    logic [2:0] m_axis_tuser;    // word_index
    logic m_axis_tlast;          // is_last_word

    digest_scoreboard sb;
    bit no_idle;
    bit hold_off;
    int idle_cycles = 0;

    sha512_hash_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sample both sides at the edge, before the driver updates
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send(logic [63:0] data, logic [3:0] cnt, logic last);
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= cnt;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // a message of n full words then a last word with count cnt
    task automatic send_message(int n, logic [3:0] cnt);
        for (int i = 0; i < n; i++)
            send(rnd64(), 4'($urandom_range(0, 15)), 1'b0);
        send(rnd64(), cnt, 1'b1);
    endtask

    // the first edge lets the last accepted transfer reach the scoreboard
    task automatic drain();
        stop_sending();
        do
            @(posedge clk);
        while (sb.exp_word.size() != 0);
    endtask

    initial
    begin
        int sent;
        int n;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        @(posedge rst_n);
        @(posedge clk);

        // directed: empty message, short counts, extremes of data, padding edges
        send(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
        send(64'h6162_6300_0000_0000, 4'd3, 1'b1);
        send(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        send(64'h0000_0000_0000_0000, 4'd8, 1'b1);
        send(64'hA5A5_A5A5_A5A5_A5A5, 4'd1, 1'b1);
        send(64'h0123_4567_89AB_CDEF, 4'd0, 1'b0);
        send(64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1);
        // 13 full words: length just fits (cnt 7) or not (cnt 8) / 14: two final blocks / 15 + 16
        send_message(13, 4'd7);
        send_message(13, 4'd8);
        drain();
        send_message(14, 4'd8);
        send_message(15, 4'd3);
        send_message(15, 4'd8);
        drain();
        sent = 82;

        // receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        for (int m = 0; m < 3; m++)
        begin
            n = $urandom_range(0, 3);
            send_message(n, 4'($urandom_range(0, 8)));
            sent += n + 1;
        end
        drain();

        while (sent < 380)
        begin
            if (sent > 320)
                no_idle = 1'b1;
            case ($urandom_range(0, 3))
                0: n = $urandom_range(0, 3);
                1: n = $urandom_range(12, 17);
                2: n = $urandom_range(28, 34);
                default: n = $urandom_range(0, 20);
            endcase
            if (n > 379 - sent)
                n = 379 - sent;
            send_message(n, 4'($urandom_range(0, 15)));
            sent += n + 1;
        end
        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.exp_word.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire
